[src/cle_pkg.sv]
`default_nettype none

package cle_pkg;

    localparam int DEF_BUF_DEPTH = 128;

    // control characters
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_EOF  = 8'h04;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_KILL = 8'h15;
    localparam logic [7:0] CH_DEL  = 8'h7f;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_ECHO  = 3'd1,
        KIND_ERASE = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_EMPTY = 3'd4,
        KIND_EOF   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        OP_IGNORE = 3'd0,
        OP_CHAR   = 3'd1,
        OP_DEL    = 3'd2,
        OP_KILL   = 3'd3,
        OP_READ   = 3'd4
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] ch;            // CR already mapped to LF
        logic       read_started;
    } t_cmd;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_char;
        logic [7:0] erase_count;
        logic       line_end;
        logic       line_ready;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_KILL_RD  = 2'd1,
        ST_KILL_CHK = 2'd2,
        ST_READ_CHK = 2'd3
    } t_back_state;

endpackage

`default_nettype wire

[src/console_line_editor.sv]
// Console line editor: canonical-mode input buffer with line editing.
// Input channel (i_in_valid / o_in_stall): i_opcode 0 carries a received
// byte in i_rx_char, i_opcode 1 is a reader asking for one byte, with
// i_read_started set once the current read has returned data.
// Output channel (o_out_valid / i_out_stall): exactly one result per input
// transfer, in order: echo, erase count, read data, empty, end of file or none.
// A front end classifies transfers into a two-entry queue, so input keeps
// flowing while a result waits; a back end runs them against the line store.
// Received bytes and empty reads resolve as they leave the queue; read data
// and end of file first wait for one registered store read. Ctrl+U walks
// back through the line, a store read then a compare for each erased byte.
// The queue takes new transfers while the back end is busy, until it is full.
// Reset (synchronous, active low) empties the queue, the output register
// and all three ring pointers; the store contents are not cleared.
// A stalled result is held; the back end does not start another command
// until the output register is free, and the queue then fills and stalls.
`default_nettype none

module console_line_editor #(
    parameter int BUF_DEPTH = cle_pkg::DEF_BUF_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_rx_char,
    input  wire logic       i_read_started,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_data_char,
    output logic [7:0]      o_erase_count,
    output logic            o_line_end,
    output logic            o_line_ready
);
    import cle_pkg::*;

    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;
    t_result result;

    // front: classify and queue
    cle_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_rx_char      (i_rx_char),
        .i_read_started (i_read_started),
        .o_q_valid      (q_valid),
        .o_q_cmd        (q_cmd),
        .i_q_pop        (q_pop)
    );

    // back: line store, pointers, result register
    cle_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_kind        = result.kind;
    assign o_data_char   = result.data_char;
    assign o_erase_count = result.erase_count;
    assign o_line_end    = result.line_end;
    assign o_line_ready  = result.line_ready;

endmodule

`default_nettype wire

[src/cle_front.sv]
`default_nettype none

// Classifies incoming transfers and queues them for the back end.
module cle_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic          i_opcode,
    input  wire logic [7:0]    i_rx_char,
    input  wire logic          i_read_started,
    output logic               o_q_valid,
    output cle_pkg::t_cmd      o_q_cmd,
    input  wire logic          i_q_pop
);
    import cle_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_cmd       cls_cmd;
    logic       push;

    always_comb begin
        cls_cmd.ch           = i_rx_char;
        cls_cmd.read_started = i_read_started;
        if (i_opcode) begin
            cls_cmd.op = OP_READ;
        end else begin
            unique case (i_rx_char)
                CH_NUL:  cls_cmd.op = OP_IGNORE;
                CH_KILL: cls_cmd.op = OP_KILL;
                CH_DEL:  cls_cmd.op = OP_DEL;
                CH_CR: begin
                    cls_cmd.op = OP_CHAR;
                    cls_cmd.ch = CH_LF;
                end
                default: cls_cmd.op = OP_CHAR;
            endcase
        end
    end

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_cmd    = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push;
        n_rd_ptr = r_rd_ptr ^ i_q_pop;
        n_count  = r_count + {1'b0, push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_cmd;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != 2'd0)
        else $error("pop from empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("queue count did not follow push");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue overfilled");

endmodule

`default_nettype wire

[src/cle_back.sv]
`default_nettype none

// Executes queued commands against the line store and holds the result.
module cle_back #(
    parameter int BUF_DEPTH = cle_pkg::DEF_BUF_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire cle_pkg::t_cmd i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output cle_pkg::t_result   o_result
);
    import cle_pkg::*;

    localparam int PW = $clog2(2 * BUF_DEPTH);
    localparam int IW = $clog2(BUF_DEPTH);
    localparam logic [PW:0] D_W     = (PW + 1)'(BUF_DEPTH);
    localparam logic [PW:0] SPAN_W  = (PW + 1)'(2 * BUF_DEPTH);
    localparam logic [PW:0] SPAN_M1 = SPAN_W - 1'b1;

    function automatic logic [IW-1:0] f_slot(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = {1'b0, p};
        if (s >= D_W) s = s - D_W;
        return s[IW-1:0];
    endfunction

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return ({1'b0, p} == SPAN_M1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] f_dec(input logic [PW-1:0] p);
        return (p == '0) ? SPAN_M1[PW-1:0] : p - 1'b1;
    endfunction

    function automatic logic [PW:0] f_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + SPAN_W - {1'b0, b});
    endfunction

    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic [IW-1:0] mem_wa, mem_ra;

    t_back_state   r_state, n_state;
    logic [PW-1:0] r_read, n_read;
    logic [PW-1:0] r_commit, n_commit;
    logic [PW-1:0] r_edit, n_edit;
    logic [7:0]    r_erased, n_erased;
    t_cmd          r_cmd, n_cmd;
    logic          r_out_valid;
    t_result       r_out, res;
    logic          finish, out_free;
    logic [PW-1:0] edit_inc, edit_dec, read_inc;
    logic [PW:0]   fill_edit, fill_commit;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign edit_inc    = f_inc(r_edit);
    assign edit_dec    = f_dec(r_edit);
    assign read_inc    = f_inc(r_read);
    assign fill_edit   = f_diff(r_edit, r_read);
    assign fill_commit = f_diff(r_commit, r_read);

    always_comb begin
        n_state  = r_state;
        n_read   = r_read;
        n_commit = r_commit;
        n_edit   = r_edit;
        n_erased = r_erased;
        n_cmd    = r_cmd;
        o_q_pop  = 1'b0;
        finish   = 1'b0;
        res      = '0;
        res.kind = KIND_NONE;
        mem_we   = 1'b0;
        mem_wa   = f_slot(r_edit);
        mem_ra   = f_slot(r_read);
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    unique case (i_q_cmd.op)
                        OP_CHAR: begin
                            finish = 1'b1;
                            if (fill_edit < D_W) begin
                                mem_we        = 1'b1;
                                n_edit        = edit_inc;
                                res.kind      = KIND_ECHO;
                                res.data_char = i_q_cmd.ch;
                                if (i_q_cmd.ch == CH_LF || i_q_cmd.ch == CH_EOF ||
                                    f_diff(edit_inc, r_read) == D_W) begin
                                    n_commit       = edit_inc;
                                    res.line_ready = 1'b1;
                                end
                            end
                        end
                        OP_DEL: begin
                            finish = 1'b1;
                            if (r_edit != r_commit) begin
                                n_edit          = edit_dec;
                                res.kind        = KIND_ERASE;
                                res.erase_count = 8'd1;
                            end
                        end
                        OP_KILL: begin
                            n_erased = 8'd0;
                            n_state  = ST_KILL_RD;
                        end
                        OP_READ: begin
                            if (r_read == r_commit) begin
                                finish   = 1'b1;
                                res.kind = KIND_EMPTY;
                            end else begin
                                n_state = ST_READ_CHK;
                            end
                        end
                        default: finish = 1'b1;
                    endcase
                end
            end
            ST_KILL_RD: begin
                mem_ra = f_slot(edit_dec);
                if (r_edit == r_commit) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_erased != 8'd0) begin
                        res.kind        = KIND_ERASE;
                        res.erase_count = r_erased;
                    end
                end else begin
                    n_state = ST_KILL_CHK;
                end
            end
            ST_KILL_CHK: begin
                if (r_rd_data == CH_LF) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_erased != 8'd0) begin
                        res.kind        = KIND_ERASE;
                        res.erase_count = r_erased;
                    end
                end else begin
                    n_edit   = edit_dec;
                    n_erased = (r_erased == 8'hff) ? r_erased : r_erased + 8'd1;
                    n_state  = ST_KILL_RD;
                end
            end
            ST_READ_CHK: begin
                finish  = 1'b1;
                n_state = ST_IDLE;
                if (r_rd_data == CH_EOF) begin
                    res.kind = KIND_EOF;
                    if (!r_cmd.read_started) n_read = read_inc;
                end else begin
                    n_read        = read_inc;
                    res.kind      = KIND_DATA;
                    res.data_char = r_rd_data;
                    res.line_end  = (r_rd_data == CH_LF);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_read      <= '0;
            r_commit    <= '0;
            r_edit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_read   <= n_read;
            r_commit <= n_commit;
            r_edit   <= n_edit;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_erased <= n_erased;
        r_cmd    <= n_cmd;
        if (finish) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= i_q_cmd.ch;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(finish && r_out_valid && i_out_stall))
        else $error("result overwrote a stalled transfer");

    a_ptr_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_commit <= fill_edit && fill_edit <= D_W)
        else $error("pointer order broken");

    a_kill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_KILL_CHK |-> r_edit != r_commit)
        else $error("line erase passed the commit point");

    a_read_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read != $past(r_read) |-> $past(r_state) == ST_READ_CHK)
        else $error("read pointer moved outside a read");

endmodule

`default_nettype wire

[test/tb.sv]
`default_nettype none

module tb;
    import cle_pkg::*;

    localparam int DEPTH      = DEF_BUF_DEPTH;
    localparam int SPAN       = 2 * DEPTH;     // pointers run modulo twice the depth
    localparam int N_ITEMS    = 1400;
    localparam int MAX_CYCLES = 1_000_000;

    // ---------------------------------------------------------------
    // Line buffer predictor and result checker. It keeps its own ring
    // and pointers and queues one expected result per input transfer.
    // ---------------------------------------------------------------
    class line_scoreboard;
        logic [7:0] line_buf [DEPTH];
        int         rd_ptr;
        int         cm_ptr;
        int         ed_ptr;
        t_result    due_q [$];
        int         n_errors;
        int         n_checked;
        int         kind_hits [6];

        function new();
            rd_ptr    = 0;
            cm_ptr    = 0;
            ed_ptr    = 0;
            n_errors  = 0;
            n_checked = 0;
            foreach (kind_hits[i]) kind_hits[i] = 0;
        endfunction

        function int fill(int a, int b);
            return (a - b + SPAN) % SPAN;
        endfunction

        function int step_up(int p);
            return (p + 1) % SPAN;
        endfunction

        function int step_down(int p);
            return (p + SPAN - 1) % SPAN;
        endfunction

        // Applies one accepted input transfer, returns the result it causes.
        function t_result note_input(logic op, logic [7:0] ch, logic rs);
            t_result    r;
            logic [7:0] c;
            int         n;
            r = '0;
            c = ch;
            n = 0;
            if (!op) begin
                if (c == CH_KILL) begin
                    // walk back to the start of the line being edited
                    while (ed_ptr != cm_ptr &&
                           line_buf[step_down(ed_ptr) % DEPTH] != CH_LF) begin
                        ed_ptr = step_down(ed_ptr);
                        n++;
                    end
                    if (n != 0) r.kind = KIND_ERASE;
                end else if (c == CH_DEL) begin
                    if (ed_ptr != cm_ptr) begin
                        ed_ptr = step_down(ed_ptr);
                        n = 1;
                        r.kind = KIND_ERASE;
                    end
                end else if (c != CH_NUL && fill(ed_ptr, rd_ptr) < DEPTH) begin
                    if (c == CH_CR) c = CH_LF;
                    r.kind = KIND_ECHO;
                    r.data_char = c;
                    line_buf[ed_ptr % DEPTH] = c;
                    ed_ptr = step_up(ed_ptr);
                    // commit on newline, Ctrl+D or a full ring
                    if (c == CH_LF || c == CH_EOF || fill(ed_ptr, rd_ptr) == DEPTH) begin
                        cm_ptr = ed_ptr;
                        r.line_ready = 1'b1;
                    end
                end
            end else begin
                if (rd_ptr == cm_ptr) begin
                    r.kind = KIND_EMPTY;
                end else begin
                    c = line_buf[rd_ptr % DEPTH];
                    if (c == CH_EOF) begin
                        // pushed back when the read already returned data
                        r.kind = KIND_EOF;
                        if (!rs) rd_ptr = step_up(rd_ptr);
                    end else begin
                        rd_ptr = step_up(rd_ptr);
                        r.kind = KIND_DATA;
                        r.data_char = c;
                        r.line_end = (c == CH_LF);
                    end
                end
            end
            r.erase_count = (n > 255) ? 8'd255 : 8'(n);
            due_q.push_back(r);
            return r;
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_checked++;
            if (due_q.size() == 0) begin
                $error("result with nothing pending: kind %0d", got.kind);
                n_errors++;
            end else begin
                want = due_q.pop_front();
                kind_hits[int'(want.kind)]++;
                if (got.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    n_errors++;
                end
                if (got.data_char !== want.data_char) begin
                    $error("data_char: expected %0h, got %0h", want.data_char, got.data_char);
                    n_errors++;
                end
                if (got.erase_count !== want.erase_count) begin
                    $error("erase_count: expected %0d, got %0d",
                           want.erase_count, got.erase_count);
                    n_errors++;
                end
                if (got.line_end !== want.line_end) begin
                    $error("line_end: expected %0b, got %0b", want.line_end, got.line_end);
                    n_errors++;
                end
                if (got.line_ready !== want.line_ready) begin
                    $error("line_ready: expected %0b, got %0b",
                           want.line_ready, got.line_ready);
                    n_errors++;
                end
            end
        endfunction
    endclass

    // ---------------------------------------------------------------
    // Block under test
    // ---------------------------------------------------------------
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       i_opcode       = 1'b0;
    logic [7:0] i_rx_char      = 8'h00;
    logic       i_read_started = 1'b0;
    logic       i_out_stall    = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_kind;
    logic [7:0] o_data_char;
    logic [7:0] o_erase_count;
    logic       o_line_end;
    logic       o_line_ready;

    console_line_editor DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_rx_char      (i_rx_char),
        .i_read_started (i_read_started),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_data_char    (o_data_char),
        .o_erase_count  (o_erase_count),
        .o_line_end     (o_line_end),
        .o_line_ready   (o_line_ready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    line_scoreboard sb = new();

    int      src_idle_pct = 24;    // percent chance the sender holds off
    int      snk_idle_pct = 64;    // percent chance the receiver stalls
    int      n_sent       = 0;     // transfers that do something, NUL bytes excluded
    int      n_cycles     = 0;
    logic    reading      = 1'b0;  // current read already returned data
    t_result last_due;

    // Receiver side: random stall, checked at every accepted result.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(t_result'({o_kind, o_data_char, o_erase_count,
                                       o_line_end, o_line_ready}));
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // One input transfer; returns in the time step in which it was taken.
    task automatic send_item(input logic op, input logic [7:0] ch, input logic rs);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_rx_char      <= ch;
        i_read_started <= rs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        last_due = sb.note_input(op, ch, rs);
        if (op || ch != CH_NUL) n_sent++;
        // idle pattern: sender light / receiver heavy, then swapped, then none
        if (n_sent < N_ITEMS / 3) begin
            src_idle_pct = 24;
            snk_idle_pct = 64;
        end else if (n_sent < 2 * N_ITEMS / 3) begin
            src_idle_pct = 64;
            snk_idle_pct = 24;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
    endtask

    // Reader asks for a byte; read_started follows the session, sometimes flipped.
    task automatic read_char(input int flip_pct);
        logic rs;
        rs = reading;
        if ($urandom_range(0, 99) < flip_pct) rs = ~rs;
        send_item(1'b1, 8'($urandom_range(0, 255)), rs);
        reading = (last_due.kind == KIND_DATA) && !last_due.line_end;
    endtask

    task automatic type_char(input logic [7:0] ch);
        send_item(1'b0, ch, 1'($urandom_range(0, 1)));
    endtask

    // Mostly printable text, some edits, now and then any byte.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 8'($urandom_range(32, 126));
        if (r < 88) return CH_DEL;
        if (r < 91) return CH_KILL;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic drain_reads();
        int k;
        k = 0;
        do begin
            read_char(0);
            k++;
        end while (last_due.kind != KIND_EMPTY && k < SPAN + 8);
    endtask

    initial begin
        int scen;
        int len;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: empty read, ignored bytes, edits, commit, EOF push-back
        send_item(1'b1, 8'h00, 1'b0);       // read with nothing committed
        type_char(CH_NUL);                  // zero byte ignored
        type_char(CH_DEL);                  // nothing to erase
        type_char(CH_KILL);                 // nothing to erase
        type_char(8'h61);
        type_char(8'hff);
        type_char(8'h80);
        type_char(CH_DEL);                  // erase one
        type_char(CH_KILL);                 // erase the rest of the line
        type_char(8'h78);
        type_char(CH_CR);                   // CR becomes LF and commits
        type_char(CH_EOF);                  // Ctrl+D commits too
        send_item(1'b1, 8'h00, 1'b0);       // data
        send_item(1'b1, 8'hff, 1'b1);       // LF ends the read
        send_item(1'b1, 8'h00, 1'b1);       // EOF kept: read already had data
        send_item(1'b1, 8'h00, 1'b0);       // EOF consumed
        send_item(1'b1, 8'h00, 1'b0);       // empty again
        reading = 1'b0;

        // ---- random sessions
        while (n_sent < N_ITEMS) begin
            scen = $urandom_range(0, 99);
            if (scen < 55) begin
                // edit a short line, mostly end it, then read part or all of it
                len = $urandom_range(0, 12);
                repeat (len) type_char(pick_char());
                case ($urandom_range(0, 4))
                    0, 1:    type_char(CH_CR);
                    2:       type_char(CH_LF);
                    3:       type_char(CH_EOF);
                    default: ;
                endcase
                repeat ($urandom_range(len / 2, len + 3)) read_char(10);
            end else if (scen < 65) begin
                // long line from an empty ring: one short of full, or 100 bytes to past full
                type_char(CH_KILL);
                drain_reads();
                len = ($urandom_range(0, 2) == 0) ? DEPTH - 1 : $urandom_range(100, DEPTH + 12);
                repeat (len) type_char(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 1) == 1) type_char(CH_KILL);
                repeat ($urandom_range(DEPTH / 2, DEPTH + 8)) read_char(5);
            end else if (scen < 80) begin
                repeat ($urandom_range(1, 6)) read_char(20);
            end else if (scen < 90) begin
                // a few bytes then Ctrl+D, read across it
                repeat ($urandom_range(0, 4)) type_char(8'($urandom_range(32, 126)));
                type_char(CH_EOF);
                repeat ($urandom_range(1, 8)) read_char(10);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
        end
        i_in_valid <= 1'b0;

        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d transfers, %0d results checked, ring depth %0d, three idle phases.",
                 n_sent, sb.n_checked, DEPTH);
        $display("Kinds seen: none %0d, echo %0d, erase %0d, data %0d, empty %0d, eof %0d.",
                 sb.kind_hits[0], sb.kind_hits[1], sb.kind_hits[2],
                 sb.kind_hits[3], sb.kind_hits[4], sb.kind_hits[5]);
        if (sb.n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
src/cle_pkg.sv
src/cle_front.sv
src/cle_back.sv
src/console_line_editor.sv
test/tb.sv
